// ===== design/koa_pkg.sv =====
// koa_pkg: shared types, constants and the arctangent table for the orbit anomaly block
// no dependencies; used by the interfaces, the arithmetic units and the top level
package koa_pkg;

  localparam int MaxIterationsDef = 64;
  localparam int AngleBitsDef     = 32;

  localparam int TimeW  = 40;
  localparam int Ang32W = 32;
  localparam int CountW = 7;
  localparam int CountMax = 127;
  localparam int EccW   = 24;
  localparam int RatioW = 32;
  localparam int MotionW = 48;
  localparam int TolW   = 16;
  localparam int CfgDataW = 48;
  localparam int CfgIdxW  = 3;

  localparam int DataW = 64;
  localparam int MulCntW = 7;
  localparam int TabDepth = 64;
  localparam int TabIdxW = 6;

  localparam logic [63:0] INV2PI_Q64 = 64'h28BE60DB9391054A;
  localparam logic [63:0] INVK_Q62   = 64'd2800459870029452960;
  localparam logic [63:0] TURN_Q62   = 64'h4000000000000000;
  localparam logic [63:0] HALF_Q62   = 64'h2000000000000000;
  localparam logic [63:0] QUARTER_Q62 = 64'h1000000000000000;

  localparam logic [TolW-1:0] TOL_RESET = 16'd6836;
  localparam logic [RatioW-1:0] RATIO_RESET = 32'h0100_0000;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ECCENTRICITY = 3'd0,
    REG_ANOMALY_RATIO = 3'd1,
    REG_MEAN_MOTION = 3'd2,
    REG_EPOCH_ANOMALY = 3'd3,
    REG_TOLERANCE = 3'd4
  } reg_idx_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_MEAN_GO,
    S_MEAN_WAIT,
    S_ROT_GO,
    S_ROT_WAIT,
    S_PI_GO,
    S_PI_WAIT,
    S_ECC_GO,
    S_ECC_WAIT,
    S_UPDATE,
    S_HALF_GO,
    S_HALF_WAIT,
    S_K_GO,
    S_K_WAIT,
    S_VEC_GO,
    S_VEC_WAIT,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic                 start;
    logic [MulCntW-1:0]   steps;
  } mul_ctl_t;

  typedef struct packed {
    logic start;
    logic vectoring;
  } cordic_ctl_t;

  typedef logic [63:0] atan_tab_t [TabDepth];

  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic atan_tab_t build_atan();
    atan_tab_t tab;
    logic [63:0] sum;
    logic [63:0] term;
    logic [127:0] prod;
    int p;
    tab[0] = 64'h0800000000000000;
    for (int i = 1; i < TabDepth; i++) begin
      sum = '0;
      for (int k = 0; k < 32; k++) begin
        p = i * (2 * k + 1);
        if (p <= 62) begin
          term = udiv64(64'h1 << (62 - p), 64'(2 * k + 1));
          if (k % 2 == 1) sum = sum - term;
          else sum = sum + term;
        end
      end
      prod = 128'(sum) * 128'(INV2PI_Q64);
      tab[i] = prod[127:64];
    end
    return tab;
  endfunction

  localparam atan_tab_t ATAN_TAB = build_atan();

endpackage

// ===== design/koa_in_if.sv =====
// koa_in_if: input channel carrying one time word
// depends on koa_pkg for field widths
interface koa_in_if;
  import koa_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [TimeW-1:0]  time_seconds;
  modport source (output valid, output time_seconds, input ready);
  modport sink (input valid, input time_seconds, output ready);
endinterface

// ===== design/koa_out_if.sv =====
// koa_out_if: result channel carrying the anomalies of one word
// depends on koa_pkg for field widths
interface koa_out_if;
  import koa_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [Ang32W-1:0]          mean_angle;
  logic signed [Ang32W-1:0]   eccentric_angle;
  logic signed [Ang32W-1:0]   true_angle;
  logic [CountW-1:0]          iteration_count;
  logic                       converged;
  modport source (output valid, output mean_angle, output eccentric_angle,
                  output true_angle, output iteration_count, output converged,
                  input ready);
  modport sink (input valid, input mean_angle, input eccentric_angle,
                input true_angle, input iteration_count, input converged,
                output ready);
endinterface

// ===== design/koa_mul.sv =====
// koa_mul: shift-add multiplier, one multiplier bit per cycle
// gives floor(a*b / 2^steps) and the low product bits; depends on koa_pkg
module koa_mul
  import koa_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  mul_ctl_t         ctl,
  input  logic [DataW-1:0] a,
  input  logic [DataW-1:0] b,
  output logic             done,
  output logic [DataW-1:0] hi,
  output logic [DataW-1:0] lo
);

  logic [DataW-1:0]   a_r, hi_r, lo_r;
  logic [MulCntW-1:0] cnt_r, last_r;
  logic               busy_r, done_r;
  logic [DataW:0]     sum;

  assign sum = {1'b0, hi_r} + (lo_r[0] ? {1'b0, a_r} : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == last_r) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      a_r    <= a;
      hi_r   <= '0;
      lo_r   <= b;
      last_r <= ctl.steps - 1'b1;
    end else if (busy_r) begin
      hi_r <= sum[DataW:1];
      lo_r <= {sum[0], lo_r[DataW-1:1]};
    end
  end

  assign done = done_r;
  assign hi   = hi_r;
  assign lo   = lo_r;

endmodule

// ===== design/koa_cordic.sv =====
// koa_cordic: iterative cordic, rotation (cos/sin) and vectoring (atan2) in q62 turns
// one micro-rotation per cycle; depends on koa_pkg for the arctangent table
module koa_cordic
  import koa_pkg::*;
#(
  parameter int ANGLE_BITS = AngleBitsDef
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cordic_ctl_t      ctl,
  input  logic [DataW-1:0] x_in,
  input  logic [DataW-1:0] y_in,
  input  logic [DataW-1:0] z_in,
  output logic             done,
  output logic [DataW-1:0] x_out,
  output logic [DataW-1:0] y_out,
  output logic [DataW-1:0] z_out
);

  logic signed [DataW-1:0] x_r, y_r, z_r;
  logic [TabIdxW-1:0]      i_r;
  logic                    busy_r, done_r, flip_r, vec_r;
  logic signed [DataW-1:0] zw, zf, dx, dy, tab;
  logic                    fold, pos;

  // wrap to signed half turn, fold into the right half plane
  always_comb begin
    zw = $signed(z_in & (TURN_Q62 - 64'd1));
    if (zw >= $signed(HALF_Q62)) zw = zw - $signed(TURN_Q62);
    fold = 1'b0;
    zf = zw;
    if (!zw[DataW-1] && zw > $signed(QUARTER_Q62)) begin
      zf = $signed(HALF_Q62) - zw;
      fold = 1'b1;
    end else if (zw[DataW-1] && zw < -$signed(QUARTER_Q62)) begin
      zf = -$signed(HALF_Q62) - zw;
      fold = 1'b1;
    end
  end

  assign dx  = y_r >>> i_r;
  assign dy  = x_r >>> i_r;
  assign tab = $signed(ATAN_TAB[i_r]);
  assign pos = vec_r ? y_r[DataW-1] : ~z_r[DataW-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      i_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        i_r    <= '0;
      end else if (busy_r) begin
        i_r <= i_r + 1'b1;
        if (i_r == TabIdxW'(ANGLE_BITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      vec_r <= ctl.vectoring;
      if (ctl.vectoring) begin
        x_r    <= $signed(x_in);
        y_r    <= $signed(y_in);
        z_r    <= $signed(z_in);
        flip_r <= 1'b0;
      end else begin
        x_r    <= $signed(INVK_Q62);
        y_r    <= '0;
        z_r    <= zf;
        flip_r <= fold;
      end
    end else if (busy_r) begin
      if (pos) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - tab;
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + tab;
      end
    end
  end

  assign done  = done_r;
  assign x_out = flip_r ? -x_r : x_r;
  assign y_out = y_r;
  assign z_out = z_r;

endmodule

// ===== design/kepler_orbit_anomaly.sv =====
// kepler_orbit_anomaly: mean, eccentric and true anomaly for one time word
// the shared multiplier and cordic units do the work in turn, the kepler step repeating
// until the tolerance is met or MAX_ITERATIONS is reached; one word in flight, input ready
// only while idle, so a new word is taken only after the last result has been registered
// synchronous active-low reset clears the sequencer and loads register defaults
module kepler_orbit_anomaly
  import koa_pkg::*;
#(
  parameter int MAX_ITERATIONS = MaxIterationsDef,
  parameter int ANGLE_BITS     = AngleBitsDef
) (
  input  logic                clk,
  input  logic                rst_n,
  koa_in_if.sink              in_ch,
  koa_out_if.source           out_ch,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  localparam int AB  = ANGLE_BITS;
  localparam int SHL = (AB >= 32) ? AB - 32 : 0;
  localparam int SHR = (AB >= 32) ? 0 : 32 - AB;
  localparam int ItW = $clog2(MAX_ITERATIONS + 1);

  logic [EccW-1:0]    ecc_r;
  logic [RatioW-1:0]  ratio_r;
  logic [MotionW-1:0] motion_r;
  logic [Ang32W-1:0]  epoch_r;
  logic [TolW-1:0]    tol_r;

  state_t state_r, state_nxt;

  logic [TimeW-1:0]   t_r;
  logic [AB-1:0]      m_r, e0_r, e1_r;
  logic [ItW-1:0]     it_r;
  logic               conv_r;
  logic [DataW-1:0]   s_r, c_r;

  logic               out_valid_r;
  logic [Ang32W-1:0]  out_mean_r, out_ecc_r, out_true_r;
  logic [CountW-1:0]  out_count_r;
  logic               out_conv_r;

  mul_ctl_t           mul_ctl;
  logic [DataW-1:0]   mul_a, mul_b, mul_hi, mul_lo;
  logic               mul_done;
  cordic_ctl_t        cor_ctl;
  logic [DataW-1:0]   cor_x, cor_y, cor_z, cor_xo, cor_yo, cor_zo;
  logic               cor_done;

  logic [55:0]        m56;
  logic [AB-1:0]      m_new, corr_a, e1_new, diff, dabs, tol_a, nu;
  logic [DataW-1:0]   corr, s_abs;
  logic [ItW-1:0]     it_inc;
  logic               in_tol, last_it, out_free;

  koa_mul u_mul (
    .clk(clk), .rst_n(rst_n), .ctl(mul_ctl), .a(mul_a), .b(mul_b),
    .done(mul_done), .hi(mul_hi), .lo(mul_lo)
  );

  koa_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic (
    .clk(clk), .rst_n(rst_n), .ctl(cor_ctl), .x_in(cor_x), .y_in(cor_y), .z_in(cor_z),
    .done(cor_done), .x_out(cor_xo), .y_out(cor_yo), .z_out(cor_zo)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ecc_r    <= '0;
      ratio_r  <= RATIO_RESET;
      motion_r <= '0;
      epoch_r  <= '0;
      tol_r    <= TOL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ECCENTRICITY:  ecc_r    <= cfg_data[EccW-1:0];
        REG_ANOMALY_RATIO: ratio_r  <= cfg_data[RatioW-1:0];
        REG_MEAN_MOTION:   motion_r <= cfg_data[MotionW-1:0];
        REG_EPOCH_ANOMALY: epoch_r  <= cfg_data[Ang32W-1:0];
        REG_TOLERANCE:     tol_r    <= cfg_data[TolW-1:0];
        default: ;
      endcase
    end
  end

  // datapath arithmetic
  always_comb begin
    m56    = {mul_hi[15:0] - (t_r[TimeW-1] ? motion_r[15:0] : 16'd0), mul_lo[63:24]};
    m_new  = AB'((64'(epoch_r) << SHL) >> SHR) + AB'(m56 >> (56 - AB));
    tol_a  = AB'((64'(tol_r) << SHL) >> SHR);
    s_abs  = s_r[DataW-1] ? -s_r : s_r;
    corr   = mul_hi >> (62 - AB);
    corr_a = AB'(corr);
    e1_new = s_r[DataW-1] ? m_r - corr_a : m_r + corr_a;
    diff   = e1_new - e0_r;
    dabs   = diff[AB-1] ? -diff : diff;
    in_tol = dabs <= tol_a;
    it_inc = it_r + 1'b1;
    last_it = it_inc == ItW'(MAX_ITERATIONS);
    nu     = AB'($signed(cor_zo) >>> (61 - AB));
    out_free = !out_valid_r || out_ch.ready;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:      if (in_ch.valid) state_nxt = S_MEAN_GO;
      S_MEAN_GO:   state_nxt = S_MEAN_WAIT;
      S_MEAN_WAIT: if (mul_done) state_nxt = S_ROT_GO;
      S_ROT_GO:    state_nxt = S_ROT_WAIT;
      S_ROT_WAIT:  if (cor_done) state_nxt = S_PI_GO;
      S_PI_GO:     state_nxt = S_PI_WAIT;
      S_PI_WAIT:   if (mul_done) state_nxt = S_ECC_GO;
      S_ECC_GO:    state_nxt = S_ECC_WAIT;
      S_ECC_WAIT:  if (mul_done) state_nxt = S_UPDATE;
      S_UPDATE:    state_nxt = (in_tol || last_it) ? S_HALF_GO : S_ROT_GO;
      S_HALF_GO:   state_nxt = S_HALF_WAIT;
      S_HALF_WAIT: if (cor_done) state_nxt = S_K_GO;
      S_K_GO:      state_nxt = S_K_WAIT;
      S_K_WAIT:    if (mul_done) state_nxt = S_VEC_GO;
      S_VEC_GO:    state_nxt = S_VEC_WAIT;
      S_VEC_WAIT:  if (cor_done) state_nxt = S_FINISH;
      S_FINISH:    if (out_free) state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  // unit control
  always_comb begin
    mul_ctl = '0;
    mul_a   = '0;
    mul_b   = '0;
    cor_ctl = '0;
    cor_x   = '0;
    cor_y   = '0;
    cor_z   = '0;
    unique case (state_r)
      S_MEAN_GO: begin
        mul_ctl = '{start: 1'b1, steps: MulCntW'(TimeW)};
        mul_a   = 64'(motion_r);
        mul_b   = 64'(t_r);
      end
      S_PI_GO: begin
        mul_ctl = '{start: 1'b1, steps: MulCntW'(DataW)};
        mul_a   = s_abs;
        mul_b   = INV2PI_Q64;
      end
      S_ECC_GO: begin
        mul_ctl = '{start: 1'b1, steps: MulCntW'(EccW)};
        mul_a   = mul_hi;
        mul_b   = 64'(ecc_r);
      end
      S_K_GO: begin
        mul_ctl = '{start: 1'b1, steps: MulCntW'(RatioW)};
        mul_a   = s_abs;
        mul_b   = 64'(ratio_r);
      end
      S_ROT_GO: begin
        cor_ctl = '{start: 1'b1, vectoring: 1'b0};
        cor_z   = 64'(e0_r) << (62 - AB);
      end
      S_HALF_GO: begin
        cor_ctl = '{start: 1'b1, vectoring: 1'b0};
        cor_z   = $signed({e1_r, {(DataW - AB){1'b0}}}) >>> 3;
      end
      S_VEC_GO: begin
        cor_ctl = '{start: 1'b1, vectoring: 1'b1};
        cor_x   = $signed(c_r) >>> 8;
        cor_y   = s_r[DataW-1] ? -mul_hi : mul_hi;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: if (in_ch.valid) t_r <= in_ch.time_seconds;
      S_MEAN_WAIT: if (mul_done) begin
        m_r  <= m_new;
        e0_r <= m_new;
        it_r <= '0;
      end
      S_ROT_WAIT: if (cor_done) s_r <= cor_yo;
      S_UPDATE: begin
        e1_r   <= e1_new;
        e0_r   <= e1_new;
        it_r   <= it_inc;
        conv_r <= in_tol;
      end
      S_HALF_WAIT: if (cor_done) begin
        s_r <= cor_yo;
        c_r <= cor_xo;
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_FINISH && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_FINISH && out_free) begin
      out_mean_r  <= 32'((64'(m_r) >> SHL) << SHR);
      out_ecc_r   <= 32'((64'(e1_r) >> SHL) << SHR);
      out_true_r  <= 32'((64'(nu) >> SHL) << SHR);
      out_count_r <= (it_r > ItW'(CountMax)) ? CountW'(CountMax) : CountW'(it_r);
      out_conv_r  <= conv_r;
    end
  end

  assign in_ch.ready            = state_r == S_IDLE;
  assign out_ch.valid           = out_valid_r;
  assign out_ch.mean_angle      = out_mean_r;
  assign out_ch.eccentric_angle = out_ecc_r;
  assign out_ch.true_angle      = out_true_r;
  assign out_ch.iteration_count = out_count_r;
  assign out_ch.converged       = out_conv_r;

endmodule
